FILE: sv/assert_macros.svh
// Assertion macros for the flow statistics table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LFST_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define LFST_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define LFST_ASSERT_IMP(label, clk, rst_n, a, b)
`define LFST_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: sv/lfst_pkg.sv
package lfst_pkg;
    localparam int DEF_MAX_FLOWS     = 64;
    localparam int DEF_HISTORY_DEPTH = 64;

    localparam int FUNC_W     = 2;
    localparam int KEY_W      = 40;
    localparam int TIME_W     = 48;
    localparam int LAST_W     = 47;
    localparam int TOTAL_W    = 32;
    localparam int SIZE_W     = 9;
    localparam int TOUCH_W    = 32;
    localparam int CAP_W      = 7;
    localparam int WIN_W      = 20;
    localparam int PKT_W      = 24;
    localparam int BYTE_W     = 33;
    localparam int FLOWCNT_W  = 7;
    localparam int DIVIDEND_W = 38;
    localparam int ELAP_W     = 48;

    localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_WINDOW   = 1'b1;

    localparam logic [CAP_W-1:0]      CAP_RESET    = 7'd64;
    localparam logic [WIN_W-1:0]      WIN_RESET    = 20'd1000;
    localparam logic [DIVIDEND_W-1:0] RATE_SCALE   = 38'd256000;
    localparam logic [DIVIDEND_W-1:0] PKT_MAX      = 38'hFFFFFF;
    localparam logic [DIVIDEND_W-1:0] BYTE_MAX     = 38'h1FFFFFFFF;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = 32'hFFFFFFFF;
endpackage

FILE: sv/lfst_ram.sv
module lfst_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/lfst_div.sv
module lfst_div
    import lfst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [ELAP_W-1:0]     divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [ELAP_W:0]       rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [ELAP_W-1:0]     den_reg, den_next;
    logic [ELAP_W:0]       rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg[ELAP_W-1:0], quo_reg[DIVIDEND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: sv/lru_flow_stats_table.sv
// Per-flow packet statistics table with least recently used replacement.
// Input channel in_valid/in_ready carries func, the flow key, wire_bytes and
// time_ms; output channel out_valid/out_ready carries one result per item.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user is
// to write it only while idle, which the block does not enforce. One item is
// worked on at a time. A query or a non-negative-time record first scans all
// MAX_FLOWS entries of the entry memory, one read per cycle, then reads the
// selected entry unless a query misses; other items skip the scan. A query hit
// with samples, at a time not before its last record, walks them in the sample
// memory, one per cycle, and runs two 38-step divisions for a positive span.
// Reset empties the table, zeroes the touch counter and restores the register
// defaults; the memories themselves are not cleared and need no sweep.
// A finished result sits in the output register until it is taken; the next
// input item is accepted meanwhile, but its result waits until the output
// register has been transferred.
module lru_flow_stats_table
    import lfst_pkg::*;
#(
    parameter int MAX_FLOWS     = DEF_MAX_FLOWS,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [7:0]           system_id,
    input  logic [7:0]           component_id,
    input  logic [23:0]          message_id,
    input  logic [SIZE_W-1:0]    wire_bytes,
    input  logic signed [TIME_W-1:0] time_ms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 ok,
    output logic                 evicted,
    output logic [TOTAL_W-1:0]   total_seen,
    output logic [LAST_W-1:0]    last_seen_ms,
    output logic [SIZE_W-1:0]    latest_size,
    output logic [PKT_W-1:0]     packet_rate_q8,
    output logic [BYTE_W-1:0]    byte_rate_q8,
    output logic [FLOWCNT_W-1:0] flow_count,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [WIN_W-1:0]     cfg_data
);
    `include "assert_macros.svh"

    localparam int IDX_W   = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int CNT_W   = $clog2(MAX_FLOWS + 1);
    localparam int HEAD_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = $clog2(HISTORY_DEPTH * 511 + 1);
    localparam int RING_D  = MAX_FLOWS * HISTORY_DEPTH;
    localparam int RING_AW = (RING_D > 1) ? $clog2(RING_D) : 1;
    localparam int SMP_W   = TIME_W + SIZE_W;
    localparam int ENT_W   = KEY_W + TIME_W + TOTAL_W + SIZE_W + TOUCH_W + FILL_W + HEAD_W;
    localparam int O_HEAD  = 0;
    localparam int O_FILL  = O_HEAD + HEAD_W;
    localparam int O_TOUCH = O_FILL + FILL_W;
    localparam int O_SIZE  = O_TOUCH + TOUCH_W;
    localparam int O_TOTAL = O_SIZE + SIZE_W;
    localparam int O_LAST  = O_TOTAL + TOTAL_W;
    localparam int O_KEY   = O_LAST + TIME_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RDENT, S_UPD, S_QSTAT, S_RING, S_ELAP,
        S_DIVP, S_WAITP, S_DIVB, S_WAITB, S_FIN
    } state_t;

    state_t                state_reg, state_next;
    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic [WIN_W-1:0]      win_reg, win_next;
    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [SIZE_W-1:0]     bytes_reg, bytes_next;
    logic [TIME_W-1:0]     t_reg, t_next;
    logic                  valid_reg [MAX_FLOWS];
    logic                  valid_next [MAX_FLOWS];
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TOUCH_W-1:0]    touch_reg, touch_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]      ev_idx_reg, ev_idx_next;
    logic                  ev_first_reg, ev_first_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic                  vic_reg, vic_next;
    logic [IDX_W-1:0]      vic_idx_reg, vic_idx_next;
    logic [TOUCH_W-1:0]    vic_touch_reg, vic_touch_next;
    logic                  free_reg, free_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic                  new_reg, new_next;
    logic [RING_AW-1:0]    base_reg, base_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [FILL_W-1:0]     ri_reg, ri_next;
    logic [HEAD_W-1:0]     ptr_reg, ptr_next;
    logic [TIME_W:0]       wstart_reg, wstart_next;
    logic [TIME_W:0]       first_reg, first_next;
    logic [FILL_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [ELAP_W-1:0]     elap_reg, elap_next;
    logic [DIVIDEND_W-1:0] prodp_reg, prodp_next;
    logic [DIVIDEND_W-1:0] prodb_reg, prodb_next;
    logic                  rok_reg, rok_next;
    logic                  rev_reg, rev_next;
    logic [TOTAL_W-1:0]    rtot_reg, rtot_next;
    logic [LAST_W-1:0]     rlast_reg, rlast_next;
    logic [SIZE_W-1:0]     rsize_reg, rsize_next;
    logic [PKT_W-1:0]      rpkt_reg, rpkt_next;
    logic [BYTE_W-1:0]     rbyte_reg, rbyte_next;
    logic                  ovld_reg, ovld_next;
    logic                  ook_reg, ook_next;
    logic                  oev_reg, oev_next;
    logic [TOTAL_W-1:0]    otot_reg, otot_next;
    logic [LAST_W-1:0]     olast_reg, olast_next;
    logic [SIZE_W-1:0]     osize_reg, osize_next;
    logic [PKT_W-1:0]      opkt_reg, opkt_next;
    logic [BYTE_W-1:0]     obyte_reg, obyte_next;
    logic [FLOWCNT_W-1:0]  ocnt_reg, ocnt_next;

    logic                  ent_we;
    logic [IDX_W-1:0]      ent_raddr;
    logic [ENT_W-1:0]      ent_wdata;
    logic [ENT_W-1:0]      ent_rdata;
    logic                  ring_we;
    logic [RING_AW-1:0]    ring_waddr;
    logic [RING_AW-1:0]    ring_raddr;
    logic [SMP_W-1:0]      ring_wdata;
    logic [SMP_W-1:0]      ring_rdata;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;

    logic [KEY_W-1:0]      e_key;
    logic [TIME_W-1:0]     e_last;
    logic [TOTAL_W-1:0]    e_total;
    logic [TOUCH_W-1:0]    e_touch;
    logic [FILL_W-1:0]     e_fill;
    logic [HEAD_W-1:0]     e_head;
    logic [SIZE_W-1:0]     e_size;
    logic [15:0]           cap_eff;
    logic [FILL_W-1:0]     u_fill;
    logic [HEAD_W-1:0]     u_head;
    logic [HEAD_W-1:0]     u_pos;
    logic [FILL_W:0]       u_sum;
    logic [TOTAL_W-1:0]    u_total;
    logic [TIME_W-1:0]     s_time;
    logic [TIME_W:0]       d_start;
    logic [TIME_W+1:0]     d_elap;

    assign e_key   = ent_rdata[O_KEY +: KEY_W];
    assign e_last  = ent_rdata[O_LAST +: TIME_W];
    assign e_total = ent_rdata[O_TOTAL +: TOTAL_W];
    assign e_size  = ent_rdata[O_SIZE +: SIZE_W];
    assign e_touch = ent_rdata[O_TOUCH +: TOUCH_W];
    assign e_fill  = ent_rdata[O_FILL +: FILL_W];
    assign e_head  = ent_rdata[O_HEAD +: HEAD_W];
    assign s_time  = ring_rdata[TIME_W-1:0];

    always_comb
    begin
        cap_eff = (cap_reg == '0) ? 16'd1 : {9'd0, cap_reg};
        if (cap_eff > 16'(MAX_FLOWS))
        begin
            cap_eff = 16'(MAX_FLOWS);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        win_next       = win_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        bytes_next     = bytes_reg;
        t_next         = t_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        touch_next     = touch_reg;
        scan_next      = scan_reg;
        ev_vld_next    = ev_vld_reg;
        ev_idx_next    = ev_idx_reg;
        ev_first_next  = ev_first_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        vic_next       = vic_reg;
        vic_idx_next   = vic_idx_reg;
        vic_touch_next = vic_touch_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        slot_next      = slot_reg;
        new_next       = new_reg;
        base_next      = base_reg;
        fill_next      = fill_reg;
        ri_next        = ri_reg;
        ptr_next       = ptr_reg;
        wstart_next    = wstart_reg;
        first_next     = first_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        elap_next      = elap_reg;
        prodp_next     = prodp_reg;
        prodb_next     = prodb_reg;
        rok_next       = rok_reg;
        rev_next       = rev_reg;
        rtot_next      = rtot_reg;
        rlast_next     = rlast_reg;
        rsize_next     = rsize_reg;
        rpkt_next      = rpkt_reg;
        rbyte_next     = rbyte_reg;
        ovld_next      = ovld_reg;
        ook_next       = ook_reg;
        oev_next       = oev_reg;
        otot_next      = otot_reg;
        olast_next     = olast_reg;
        osize_next     = osize_reg;
        opkt_next      = opkt_reg;
        obyte_next     = obyte_reg;
        ocnt_next      = ocnt_reg;
        ent_we         = 1'b0;
        ent_raddr      = slot_reg;
        ent_wdata      = '0;
        ring_we        = 1'b0;
        ring_waddr     = '0;
        ring_raddr     = '0;
        ring_wdata     = '0;
        div_start      = 1'b0;
        div_dividend   = prodp_reg;
        u_fill         = '0;
        u_head         = '0;
        u_pos          = '0;
        u_sum          = '0;
        u_total        = '0;
        d_start        = '0;
        d_elap         = '0;

        if (cfg_we)
        begin
            if (cfg_index == CFG_CAPACITY)
            begin
                cap_next = cfg_data[CAP_W-1:0];
            end
            else
            begin
                win_next = cfg_data;
            end
        end

        if (ovld_reg && out_ready)
        begin
            ovld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next    = func;
                    key_next     = {system_id, component_id, message_id};
                    bytes_next   = wire_bytes;
                    t_next       = time_ms;
                    scan_next    = '0;
                    ev_vld_next  = 1'b0;
                    hit_next     = 1'b0;
                    vic_next     = 1'b0;
                    free_next    = 1'b0;
                    rok_next     = 1'b0;
                    rev_next     = 1'b0;
                    rtot_next    = '0;
                    rlast_next   = '0;
                    rsize_next   = '0;
                    rpkt_next    = '0;
                    rbyte_next   = '0;
                    state_next   = S_FIN;
                    case (func)
                        FUNC_RECORD:
                        begin
                            if (!time_ms[TIME_W-1])
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            state_next = S_SCAN;
                        end
                        FUNC_CLEAR:
                        begin
                            for (int i = 0; i < MAX_FLOWS; i++)
                            begin
                                valid_next[i] = 1'b0;
                            end
                            count_next = '0;
                            touch_next = '0;
                            rok_next   = 1'b1;
                        end
                        default:
                        begin
                            rok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (ev_vld_reg)
                begin
                    if (valid_reg[ev_idx_reg])
                    begin
                        if (!hit_reg && e_key == key_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = ev_idx_reg;
                        end
                        if (!vic_reg || e_touch < vic_touch_reg)
                        begin
                            vic_next       = 1'b1;
                            vic_idx_next   = ev_idx_reg;
                            vic_touch_next = e_touch;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = ev_idx_reg;
                    end
                end
                if (scan_reg < CNT_W'(MAX_FLOWS))
                begin
                    ent_raddr   = scan_reg[IDX_W-1:0];
                    ev_idx_next = scan_reg[IDX_W-1:0];
                    ev_vld_next = 1'b1;
                    scan_next   = scan_reg + 1'b1;
                end
                else
                begin
                    ev_vld_next = 1'b0;
                    if (!ev_vld_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                state_next = S_RDENT;
                if (func_reg == FUNC_QUERY)
                begin
                    slot_next = hit_idx_reg;
                    if (!hit_reg)
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (hit_reg)
                begin
                    slot_next = hit_idx_reg;
                    new_next  = 1'b0;
                end
                else
                begin
                    new_next = 1'b1;
                    if (16'(count_reg) >= cap_eff)
                    begin
                        valid_next[vic_idx_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                        rev_next   = 1'b1;
                        if (free_reg && free_idx_reg < vic_idx_reg)
                        begin
                            slot_next = free_idx_reg;
                        end
                        else
                        begin
                            slot_next = vic_idx_reg;
                        end
                    end
                    else
                    begin
                        slot_next = free_idx_reg;
                    end
                end
            end
            S_RDENT:
            begin
                ent_raddr = slot_reg;
                base_next = RING_AW'(slot_reg) * RING_AW'(HISTORY_DEPTH);
                state_next = (func_reg == FUNC_QUERY) ? S_QSTAT : S_UPD;
            end
            S_UPD:
            begin
                if (new_reg || ($signed(t_reg) < $signed(e_last)))
                begin
                    u_fill = '0;
                    u_head = '0;
                end
                else
                begin
                    u_fill = e_fill;
                    u_head = e_head;
                end
                if (new_reg)
                begin
                    u_total = TOTAL_W'(1);
                end
                else if (e_total == TOTAL_MAX)
                begin
                    u_total = e_total;
                end
                else
                begin
                    u_total = e_total + 1'b1;
                end
                u_sum = (FILL_W + 1)'(u_head) + (FILL_W + 1)'(u_fill);
                if (u_sum >= (FILL_W + 1)'(HISTORY_DEPTH))
                begin
                    u_sum = u_sum - (FILL_W + 1)'(HISTORY_DEPTH);
                end
                if (u_fill < FILL_W'(HISTORY_DEPTH))
                begin
                    u_pos  = u_sum[HEAD_W-1:0];
                    u_fill = u_fill + 1'b1;
                end
                else
                begin
                    u_pos  = u_head;
                    u_head = (u_head == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : u_head + 1'b1;
                end
                ring_we    = 1'b1;
                ring_waddr = base_reg + RING_AW'(u_pos);
                ring_wdata = {bytes_reg, t_reg};
                ent_we     = 1'b1;
                ent_wdata  = {key_reg, t_reg, u_total, bytes_reg, touch_reg + 1'b1,
                              u_fill, u_head};
                touch_next = touch_reg + 1'b1;
                valid_next[slot_reg] = 1'b1;
                if (new_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                rok_next   = 1'b1;
                state_next = S_FIN;
            end
            S_QSTAT:
            begin
                rok_next   = 1'b1;
                rtot_next  = e_total;
                rlast_next = e_last[LAST_W-1:0];
                rsize_next = e_size;
                fill_next  = e_fill;
                ptr_next   = e_head;
                ri_next    = '0;
                cnt_next   = '0;
                sum_next   = '0;
                ev_vld_next = 1'b0;
                wstart_next = {t_reg[TIME_W-1], t_reg} - {{(TIME_W + 1 - WIN_W){1'b0}}, win_reg};
                if (e_fill != '0 && !t_reg[TIME_W-1] && !($signed(t_reg) < $signed(e_last)))
                begin
                    state_next = S_RING;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RING:
            begin
                if (ev_vld_reg)
                begin
                    if (ev_first_reg)
                    begin
                        first_next = {s_time[TIME_W-1], s_time};
                    end
                    if ($signed({s_time[TIME_W-1], s_time}) > $signed(wstart_reg) &&
                        $signed(s_time) < $signed(t_reg))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        sum_next = sum_reg + SUM_W'(ring_rdata[SMP_W-1:TIME_W]);
                    end
                end
                if (ri_reg < fill_reg)
                begin
                    ring_raddr    = base_reg + RING_AW'(ptr_reg);
                    ptr_next      = (ptr_reg == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    ri_next       = ri_reg + 1'b1;
                    ev_vld_next   = 1'b1;
                    ev_first_next = (ri_reg == '0);
                end
                else
                begin
                    ev_vld_next = 1'b0;
                    if (!ev_vld_reg)
                    begin
                        state_next = S_ELAP;
                    end
                end
            end
            S_ELAP:
            begin
                d_start = ($signed(wstart_reg) > $signed(first_reg)) ? wstart_reg : first_reg;
                d_elap  = {t_reg[TIME_W-1], t_reg[TIME_W-1], t_reg} -
                          {d_start[TIME_W], d_start};
                if (!d_elap[TIME_W+1] && d_elap != '0)
                begin
                    elap_next  = d_elap[ELAP_W-1:0];
                    prodp_next = DIVIDEND_W'(cnt_reg) * RATE_SCALE;
                    prodb_next = DIVIDEND_W'(sum_reg) * RATE_SCALE;
                    state_next = S_DIVP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIVP:
            begin
                div_start    = 1'b1;
                div_dividend = prodp_reg;
                state_next   = S_WAITP;
            end
            S_WAITP:
            begin
                if (div_done)
                begin
                    rpkt_next  = (div_quo > PKT_MAX) ? PKT_MAX[PKT_W-1:0] : div_quo[PKT_W-1:0];
                    state_next = S_DIVB;
                end
            end
            S_DIVB:
            begin
                div_start    = 1'b1;
                div_dividend = prodb_reg;
                state_next   = S_WAITB;
            end
            S_WAITB:
            begin
                if (div_done)
                begin
                    rbyte_next = (div_quo > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0]
                                                      : div_quo[BYTE_W-1:0];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ovld_reg || out_ready)
                begin
                    ovld_next  = 1'b1;
                    ook_next   = rok_reg;
                    oev_next   = rev_reg;
                    otot_next  = rtot_reg;
                    olast_next = rlast_reg;
                    osize_next = rsize_reg;
                    opkt_next  = rpkt_reg;
                    obyte_next = rbyte_reg;
                    ocnt_next  = FLOWCNT_W'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            win_reg       <= WIN_RESET;
            func_reg      <= '0;
            key_reg       <= '0;
            bytes_reg     <= '0;
            t_reg         <= '0;
            for (int i = 0; i < MAX_FLOWS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            count_reg     <= '0;
            touch_reg     <= '0;
            scan_reg      <= '0;
            ev_vld_reg    <= 1'b0;
            ev_idx_reg    <= '0;
            ev_first_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            vic_reg       <= 1'b0;
            vic_idx_reg   <= '0;
            vic_touch_reg <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            slot_reg      <= '0;
            new_reg       <= 1'b0;
            base_reg      <= '0;
            fill_reg      <= '0;
            ri_reg        <= '0;
            ptr_reg       <= '0;
            wstart_reg    <= '0;
            first_reg     <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            elap_reg      <= '0;
            prodp_reg     <= '0;
            prodb_reg     <= '0;
            rok_reg       <= 1'b0;
            rev_reg       <= 1'b0;
            rtot_reg      <= '0;
            rlast_reg     <= '0;
            rsize_reg     <= '0;
            rpkt_reg      <= '0;
            rbyte_reg     <= '0;
            ovld_reg      <= 1'b0;
            ook_reg       <= 1'b0;
            oev_reg       <= 1'b0;
            otot_reg      <= '0;
            olast_reg     <= '0;
            osize_reg     <= '0;
            opkt_reg      <= '0;
            obyte_reg     <= '0;
            ocnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            win_reg       <= win_next;
            func_reg      <= func_next;
            key_reg       <= key_next;
            bytes_reg     <= bytes_next;
            t_reg         <= t_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            touch_reg     <= touch_next;
            scan_reg      <= scan_next;
            ev_vld_reg    <= ev_vld_next;
            ev_idx_reg    <= ev_idx_next;
            ev_first_reg  <= ev_first_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            vic_reg       <= vic_next;
            vic_idx_reg   <= vic_idx_next;
            vic_touch_reg <= vic_touch_next;
            free_reg      <= free_next;
            free_idx_reg  <= free_idx_next;
            slot_reg      <= slot_next;
            new_reg       <= new_next;
            base_reg      <= base_next;
            fill_reg      <= fill_next;
            ri_reg        <= ri_next;
            ptr_reg       <= ptr_next;
            wstart_reg    <= wstart_next;
            first_reg     <= first_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            elap_reg      <= elap_next;
            prodp_reg     <= prodp_next;
            prodb_reg     <= prodb_next;
            rok_reg       <= rok_next;
            rev_reg       <= rev_next;
            rtot_reg      <= rtot_next;
            rlast_reg     <= rlast_next;
            rsize_reg     <= rsize_next;
            rpkt_reg      <= rpkt_next;
            rbyte_reg     <= rbyte_next;
            ovld_reg      <= ovld_next;
            ook_reg       <= ook_next;
            oev_reg       <= oev_next;
            otot_reg      <= otot_next;
            olast_reg     <= olast_next;
            osize_reg     <= osize_next;
            opkt_reg      <= opkt_next;
            obyte_reg     <= obyte_next;
            ocnt_reg      <= ocnt_next;
        end
    end

    lfst_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_FLOWS)
    ) u_ent_ram (
        .clk  (clk),
        .we   (ent_we),
        .waddr(slot_reg),
        .wdata(ent_wdata),
        .raddr(ent_raddr),
        .rdata(ent_rdata)
    );

    lfst_ram #(
        .WIDTH(SMP_W),
        .DEPTH(RING_D)
    ) u_ring_ram (
        .clk  (clk),
        .we   (ring_we),
        .waddr(ring_waddr),
        .wdata(ring_wdata),
        .raddr(ring_raddr),
        .rdata(ring_rdata)
    );

    lfst_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (elap_reg),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = ovld_reg;
    assign ok             = ook_reg;
    assign evicted        = oev_reg;
    assign total_seen     = otot_reg;
    assign last_seen_ms   = olast_reg;
    assign latest_size    = osize_reg;
    assign packet_rate_q8 = opkt_reg;
    assign byte_rate_q8   = obyte_reg;
    assign flow_count     = ocnt_reg;

    `LFST_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_FLOWS))
    `LFST_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `LFST_ASSERT_IMP(a_evict_needs_ok, clk, rst_n, out_valid && evicted, ok)
endmodule

FILE: test/lru_flow_stats_table_checker.sv
`timescale 1ns / 1ps

module lru_flow_stats_table_checker
    import lfst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic [7:0]               system_id,
    input  logic [7:0]               component_id,
    input  logic [23:0]              message_id,
    input  logic [SIZE_W-1:0]        wire_bytes,
    input  logic signed [TIME_W-1:0] time_ms,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     ok,
    input  logic                     evicted,
    input  logic [TOTAL_W-1:0]       total_seen,
    input  logic [LAST_W-1:0]        last_seen_ms,
    input  logic [SIZE_W-1:0]        latest_size,
    input  logic [PKT_W-1:0]         packet_rate_q8,
    input  logic [BYTE_W-1:0]        byte_rate_q8,
    input  logic [FLOWCNT_W-1:0]     flow_count,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [WIN_W-1:0]         cfg_data,
    output int                       failures,
    output int                       pending
);
    localparam int NF = DEF_MAX_FLOWS;
    localparam int ND = DEF_HISTORY_DEPTH;

    typedef struct packed {
        logic                 ok;
        logic                 evicted;
        logic [TOTAL_W-1:0]   total;
        logic [LAST_W-1:0]    last;
        logic [SIZE_W-1:0]    size;
        logic [PKT_W-1:0]     pkt;
        logic [BYTE_W-1:0]    byt;
        logic [FLOWCNT_W-1:0] count;
    } flow_result_t;

    flow_result_t result_fifo[$];

    logic [CAP_W-1:0]   capacity;
    logic [WIN_W-1:0]   window;
    bit                 used [NF];
    logic [KEY_W-1:0]   keys [NF];
    longint             last_t [NF];
    logic [TOTAL_W-1:0] totals [NF];
    logic [SIZE_W-1:0]  sizes [NF];
    logic [TOUCH_W-1:0] touches [NF];
    longint             smp_t [NF][ND];
    int                 smp_b [NF][ND];
    int                 fill [NF];
    int                 head [NF];
    logic [TOUCH_W-1:0] touch_cnt;

    function automatic int flows_held();
        int n;
        n = 0;
        for (int i = 0; i < NF; i++)
            if (used[i])
                n++;
        return n;
    endfunction

    function automatic int find_slot(logic [KEY_W-1:0] k);
        for (int i = 0; i < NF; i++)
            if (used[i] && keys[i] == k)
                return i;
        return -1;
    endfunction

    function automatic logic [63:0] scaled_rate(longint amount, longint span, longint top);
        longint r;
        r = (amount * 256000) / span;
        return (r > top) ? top : r;
    endfunction

    function automatic flow_result_t predict_flow_item(logic [FUNC_W-1:0] f,
        logic [KEY_W-1:0] k, logic [SIZE_W-1:0] b, longint t);
        flow_result_t r;
        int s, lim, victim, idx;
        longint ws, first, ds, el, cnt, sum;
        r = '0;
        if (f == FUNC_RECORD) begin
            if (t >= 0) begin
                lim = capacity;
                if (lim < 1) lim = 1;
                if (lim > NF) lim = NF;
                s = find_slot(k);
                if (s < 0) begin
                    if (flows_held() >= lim) begin
                        victim = -1;
                        for (int i = 0; i < NF; i++)
                            if (used[i] && (victim < 0 || touches[i] < touches[victim]))
                                victim = i;
                        if (victim >= 0)
                            used[victim] = 0;
                        r.evicted = 1;
                    end
                    for (int i = NF - 1; i >= 0; i--)
                        if (!used[i])
                            s = i;
                    used[s] = 1;
                    keys[s] = k;
                    totals[s] = 0;
                    fill[s] = 0;
                    head[s] = 0;
                end
                else if (t < last_t[s]) begin
                    fill[s] = 0;
                    head[s] = 0;
                end
                last_t[s] = t;
                if (totals[s] != TOTAL_MAX)
                    totals[s]++;
                sizes[s] = b;
                touch_cnt++;
                touches[s] = touch_cnt;
                if (fill[s] < ND) begin
                    idx = (head[s] + fill[s]) % ND;
                    fill[s]++;
                end
                else begin
                    idx = head[s];
                    head[s] = (head[s] + 1) % ND;
                end
                smp_t[s][idx] = t;
                smp_b[s][idx] = b;
                r.ok = 1;
            end
        end
        else if (f == FUNC_QUERY) begin
            s = find_slot(k);
            if (s >= 0) begin
                r.ok = 1;
                r.total = totals[s];
                r.last = last_t[s][LAST_W-1:0];
                r.size = sizes[s];
                if (fill[s] > 0 && t >= 0 && t >= last_t[s]) begin
                    ws = t - longint'(window);
                    first = smp_t[s][head[s]];
                    ds = (ws > first) ? ws : first;
                    el = t - ds;
                    if (el > 0) begin
                        cnt = 0;
                        sum = 0;
                        for (int i = 0; i < fill[s]; i++) begin
                            idx = (head[s] + i) % ND;
                            if (smp_t[s][idx] > ws && smp_t[s][idx] < t) begin
                                cnt++;
                                sum += smp_b[s][idx];
                            end
                        end
                        r.pkt = PKT_W'(scaled_rate(cnt, el, PKT_MAX));
                        r.byt = BYTE_W'(scaled_rate(sum, el, BYTE_MAX));
                    end
                end
            end
        end
        else if (f == FUNC_CLEAR) begin
            for (int i = 0; i < NF; i++)
                used[i] = 0;
            touch_cnt = 0;
            r.ok = 1;
        end
        r.count = FLOWCNT_W'(flows_held());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        failures++;
    endtask

    initial
    begin
        failures = 0;
        pending = 0;
        capacity = CAP_RESET;
        window = WIN_RESET;
        touch_cnt = 0;
        for (int i = 0; i < NF; i++)
            used[i] = 0;
    end

    always @(posedge clk)
    begin
        flow_result_t want;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == CFG_CAPACITY)
                    capacity = cfg_data[CAP_W-1:0];
                else
                    window = cfg_data;
            end
            if (in_valid && in_ready)
                result_fifo.push_back(predict_flow_item(func,
                    {system_id, component_id, message_id}, wire_bytes, longint'(time_ms)));
            if (out_valid && out_ready) begin
                if (result_fifo.size() == 0) begin
                    $display("%0t result transfer with nothing expected", $realtime);
                    failures++;
                end
                else begin
                    want = result_fifo.pop_front();
                    if (ok !== want.ok) report_mismatch("ok", ok, want.ok);
                    if (evicted !== want.evicted)
                        report_mismatch("evicted", evicted, want.evicted);
                    if (total_seen !== want.total)
                        report_mismatch("total_seen", total_seen, want.total);
                    if (last_seen_ms !== want.last)
                        report_mismatch("last_seen_ms", last_seen_ms, want.last);
                    if (latest_size !== want.size)
                        report_mismatch("latest_size", latest_size, want.size);
                    if (packet_rate_q8 !== want.pkt)
                        report_mismatch("packet_rate_q8", packet_rate_q8, want.pkt);
                    if (byte_rate_q8 !== want.byt)
                        report_mismatch("byte_rate_q8", byte_rate_q8, want.byt);
                    if (flow_count !== want.count)
                        report_mismatch("flow_count", flow_count, want.count);
                end
            end
            pending = result_fifo.size();
        end
    end
endmodule

FILE: test/lru_flow_stats_table_tb.sv
`timescale 1ns / 1ps

module lru_flow_stats_table_tb;
    import lfst_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [FUNC_W-1:0]        func;
    logic [7:0]               system_id;
    logic [7:0]               component_id;
    logic [23:0]              message_id;
    logic [SIZE_W-1:0]        wire_bytes;
    logic signed [TIME_W-1:0] time_ms;
    logic                     out_valid;
    logic                     out_ready;
    logic                     ok;
    logic                     evicted;
    logic [TOTAL_W-1:0]       total_seen;
    logic [LAST_W-1:0]        last_seen_ms;
    logic [SIZE_W-1:0]        latest_size;
    logic [PKT_W-1:0]         packet_rate_q8;
    logic [BYTE_W-1:0]        byte_rate_q8;
    logic [FLOWCNT_W-1:0]     flow_count;
    logic                     cfg_we;
    logic                     cfg_index;
    logic [WIN_W-1:0]         cfg_data;
    int                       failures;
    int                       pending;
    bit                       calm;
    int                       idle_cycles;
    longint                   clock_ms;
    logic [7:0]               sys_pool [8];
    logic [23:0]              msg_pool [8];

    lru_flow_stats_table dut (.*);
    lru_flow_stats_table_checker checker_inst (.*);

    initial clk = 0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("lru_flow_stats_table regression: fail");
            $finish;
        end
    end

    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm || $urandom_range(0, 3) != 0) begin
                out_ready = 1;
            end
            else begin
                out_ready = 0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_ready = 1;
            end
        end
    end

    task automatic send_item(logic [FUNC_W-1:0] f, logic [7:0] sy, logic [7:0] co,
        logic [23:0] mi, logic [SIZE_W-1:0] wb, logic signed [TIME_W-1:0] tm);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 10)) @(negedge clk);
        func = f;
        system_id = sy;
        component_id = co;
        message_id = mi;
        wire_bytes = wb;
        time_ms = tm;
        in_valid = 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic write_reg(logic idx, logic [WIN_W-1:0] value);
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic random_phase(int n);
        int k;
        logic [FUNC_W-1:0] f;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 7);
            clock_ms += $urandom_range(0, 400);
            f = ($urandom_range(0, 9) < 6) ? FUNC_RECORD : FUNC_QUERY;
            if ($urandom_range(0, 60) == 0) f = FUNC_CLEAR;
            if ($urandom_range(0, 80) == 0) f = FUNC_NONE;
            if ($urandom_range(0, 9) == 0)
                send_item(f, 8'($urandom), 8'($urandom), 24'($urandom),
                    SIZE_W'($urandom_range(0, 280)), TIME_W'({$urandom, $urandom}));
            else if ($urandom_range(0, 19) == 0)
                send_item(f, sys_pool[k], 8'd1, msg_pool[k], SIZE_W'($urandom_range(0, 280)),
                    TIME_W'(clock_ms - $urandom_range(1, 3000)));
            else
                send_item(f, sys_pool[k], 8'd1, msg_pool[k], SIZE_W'($urandom_range(0, 280)),
                    TIME_W'(clock_ms));
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        calm = 0;
        idle_cycles = 0;
        func = FUNC_RECORD;
        system_id = 0;
        component_id = 0;
        message_id = 0;
        wire_bytes = 0;
        time_ms = 0;
        cfg_we = 0;
        cfg_index = CFG_CAPACITY;
        cfg_data = 0;
        clock_ms = 1000;
        for (int i = 0; i < 8; i++)
        begin
            sys_pool[i] = 8'($urandom);
            msg_pool[i] = 24'($urandom);
        end
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_item(FUNC_RECORD, 8'hFF, 8'hFF, 24'hFFFFFF, 9'd280, 48'sd100);
        send_item(FUNC_RECORD, 8'hFF, 8'hFF, 24'hFFFFFF, 9'd0, 48'sd600);
        send_item(FUNC_RECORD, 8'h00, 8'h00, 24'h000000, 9'd1, 48'sh7FFFFFFFFFFF);
        send_item(FUNC_QUERY, 8'h00, 8'h00, 24'h000000, 9'd0, 48'sh7FFFFFFFFFFF);
        send_item(FUNC_QUERY, 8'hFF, 8'hFF, 24'hFFFFFF, 9'd0, 48'sd900);
        send_item(FUNC_QUERY, 8'hFF, 8'hFF, 24'hFFFFFF, 9'd0, 48'sd600);
        send_item(FUNC_QUERY, 8'hFF, 8'hFF, 24'hFFFFFF, 9'd0, -48'sd5);
        send_item(FUNC_RECORD, 8'h12, 8'h34, 24'h56, 9'd10, -48'sd1);
        send_item(FUNC_RECORD, 8'h12, 8'h34, 24'h56, 9'd10, 48'sh800000000000);
        send_item(FUNC_QUERY, 8'h12, 8'h34, 24'h56, 9'd0, 48'sd0);
        send_item(FUNC_RECORD, 8'hFF, 8'hFF, 24'hFFFFFF, 9'd77, 48'sd50);
        send_item(FUNC_QUERY, 8'hFF, 8'hFF, 24'hFFFFFF, 9'd0, 48'sd60);
        send_item(FUNC_NONE, 8'hAA, 8'h55, 24'hA5A5A5, 9'h155, 48'sh555555555555);
        send_item(FUNC_CLEAR, 8'h00, 8'h00, 24'h0, 9'd0, 48'sd0);
        send_item(FUNC_QUERY, 8'hFF, 8'hFF, 24'hFFFFFF, 9'd0, 48'sd60);

        write_reg(CFG_CAPACITY, 20'd2);
        write_reg(CFG_WINDOW, 20'd1);
        for (int i = 0; i < 4; i++)
            send_item(FUNC_RECORD, 8'd1, 8'd1, 24'(i), 9'd5, 48'sd10);
        send_item(FUNC_QUERY, 8'd1, 8'd1, 24'd3, 9'd0, 48'sd11);

        write_reg(CFG_CAPACITY, 20'd0);
        random_phase(150);
        write_reg(CFG_CAPACITY, 20'd5);
        write_reg(CFG_WINDOW, 20'd600000);
        random_phase(150);
        write_reg(CFG_CAPACITY, 20'h7F);
        write_reg(CFG_WINDOW, 20'hFFFFF);
        random_phase(150);
        write_reg(CFG_CAPACITY, 20'd3);
        write_reg(CFG_WINDOW, 20'd1000);
        random_phase(150);
        write_reg(CFG_CAPACITY, 20'd64);
        calm = 1;
        random_phase(130);

        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (failures == 0)
            $display("lru_flow_stats_table regression: pass");
        else
            $display("lru_flow_stats_table regression: fail");
        $finish;
    end
endmodule
